// ===== rtl/gak_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package gak_pkg;

   // Number of axes with their own filter state.
   localparam int NUM_AXES = 3;
   localparam int AXIS_IDX_W = (NUM_AXES > 1) ? $clog2(NUM_AXES) : 1;

   // Configuration port geometry and register reset values.
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;
   localparam int CFG_W = 31;
   localparam logic [CFG_W-1:0] TIME_STEP_RESET = 31'd328;
   localparam logic [CFG_W-1:0] ANGLE_NOISE_RESET = 31'd66;
   localparam logic [CFG_W-1:0] BIAS_NOISE_RESET = 31'd197;
   localparam logic [CFG_W-1:0] MEAS_NOISE_RESET = 31'd32768;

   // One in Q16.16.
   localparam logic signed [31:0] Q_ONE = 32'sd65536;

   // Divider geometry: the dividend is |p| * 65536 plus half the divisor.
   localparam int DIV_W = 48;
   localparam int DIV_CNT_W = $clog2(DIV_W + 1);

   typedef enum logic [1:0] {
      CSR_TIME_STEP   = 2'd0,
      CSR_ANGLE_NOISE = 2'd1,
      CSR_BIAS_NOISE  = 2'd2,
      CSR_MEAS_NOISE  = 2'd3
   } csr_idx_type;

   typedef struct packed {
      logic [1:0]         axis;
      logic signed [31:0] measured_angle;
      logic signed [31:0] gyro_rate;
   } req_type;

   typedef struct packed {
      logic [1:0]         axis_out;
      logic signed [31:0] angle_estimate;
      logic signed [31:0] corrected_rate;
   } rsp_type;

   // Sequencer steps: predict, two divisions, correct, write back.
   typedef enum logic [4:0] {
      ST_IDLE,
      ST_P0, ST_P1, ST_P2, ST_P3, ST_P4, ST_P5, ST_P6, ST_P7, ST_P8,
      ST_K0_GO, ST_K0_WAIT, ST_K1_GO, ST_K1_WAIT,
      ST_C0, ST_C1, ST_C2, ST_C3, ST_C4, ST_C5, ST_C6, ST_C7, ST_C8,
      ST_WB
   } state_type;

   // Destination of the shared adder result.
   typedef enum logic [3:0] {
      D_NONE, D_RATE, D_TMP, D_P00, D_P01, D_P10, D_P11,
      D_ANG, D_BIAS, D_ERR, D_E
   } dst_type;

   // Saturate a 34-bit sum to the signed 32-bit range.
   function automatic logic signed [31:0] sat34(input logic signed [33:0] v);
      logic signed [31:0] r;
      if (!v[33] && (v[32] || v[31])) r = 32'sh7FFFFFFF;
      else if (v[33] && !(v[32] && v[31])) r = 32'sh80000000;
      else r = v[31:0];
      return r;
   endfunction

   // Saturate a 48-bit value to the signed 32-bit range.
   function automatic logic signed [31:0] sat48(input logic signed [47:0] v);
      logic signed [31:0] r;
      if (!v[47] && (|v[46:31])) r = 32'sh7FFFFFFF;
      else if (v[47] && !(&v[46:31])) r = 32'sh80000000;
      else r = v[31:0];
      return r;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/gak_divider.sv =====
`timescale 1ns / 1ps
`default_nettype none

module gak_divider
   import gak_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   input  wire logic signed [31:0] numer,
   input  wire logic [31:0]        denom,
   output logic                    done,
   output logic signed [31:0]      quot
);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIV_CNT_W-1:0] count_ff, count_in;
   logic [DIV_W-1:0]     dvd_ff, dvd_in;
   logic [32:0]          rem_ff, rem_in;
   logic [31:0]          den_ff, den_in;
   logic                 neg_ff, neg_in;

   logic [31:0]      mag32;
   logic [DIV_W-1:0] dividend;
   logic [32:0]      rem_sh;
   logic             qbit;

   // Magnitude of the scaled numerator plus half the divisor for rounding.
   always_comb begin
      mag32 = numer[31] ? 32'(-33'(numer)) : 32'(numer);
      dividend = {mag32, 16'h0000} + DIV_W'(denom >> 1);
   end

   // One restoring step per cycle; quotient bits shift into the dividend.
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      count_in = count_ff;
      dvd_in = dvd_ff;
      rem_in = rem_ff;
      den_in = den_ff;
      neg_in = neg_ff;
      rem_sh = {rem_ff[31:0], dvd_ff[DIV_W-1]};
      qbit = (rem_sh >= {1'b0, den_ff});
      if (start) begin
         busy_in = 1'b1;
         count_in = DIV_CNT_W'(DIV_W);
         dvd_in = dividend;
         rem_in = '0;
         den_in = denom;
         neg_in = numer[31];
      end else if (busy_ff) begin
         dvd_in = {dvd_ff[DIV_W-2:0], qbit};
         rem_in = qbit ? (rem_sh - {1'b0, den_ff}) : rem_sh;
         count_in = count_ff - 1'b1;
         if (count_ff == DIV_CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         count_ff <= count_in;
      end
      dvd_ff <= dvd_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      neg_ff <= neg_in;
   end

   // Apply the sign and saturate to the Q16.16 range.
   always_comb begin
      if (neg_ff) begin
         if (dvd_ff > DIV_W'(48'h80000000)) quot = 32'sh80000000;
         else quot = 32'(-$signed({1'b0, dvd_ff}));
      end else begin
         if (dvd_ff > DIV_W'(48'h7FFFFFFF)) quot = 32'sh7FFFFFFF;
         else quot = 32'(dvd_ff);
      end
   end

   assign done = done_ff;

endmodule

`default_nettype wire

// ===== rtl/gyro_accel_angle_kalman_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Two-state angle and gyro-bias Kalman filter, one axis per input word.
// Input channel req_*: a word carries the axis, the accelerometer angle and
// the gyro rate in signed Q16.16; it is taken when req_valid is high and
// req_stall is low. req_stall is high while a word is being worked on.
// Result channel rsp_*: one word per input word, carrying the axis, the
// filtered angle and the bias-corrected rate; it is taken when rsp_valid
// is high and rsp_stall is low. The result sits in an output register, so
// the next input word is taken while a result still waits downstream.
// A valid axis passes through nine predict steps, two divisions (48
// restoring steps each in the shared divider, plus a start step and a
// wait step), nine correction steps and one write-back step, all on one
// multiplier and one adder. A new word is taken only once the sequencer
// is back in idle. An axis out of range goes straight to write-back,
// returns zero angle and rate, and leaves the state untouched. If the
// result register is still full when a new result is done, the sequencer
// waits in its write-back step until it drains.
// Configuration goes through the APB port at byte addresses 0, 4, 8, 12.
// Reset restores the register defaults, zero angle and bias, and an
// identity covariance on every axis.
module gyro_accel_angle_kalman_unit
   import gak_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire req_type               req_data,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output rsp_type                    rsp_data,
   input  wire logic                  psel,
   input  wire logic                  penable,
   input  wire logic                  pwrite,
   input  wire logic [CSR_ADDR_W-1:0] paddr,
   input  wire logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0]      prdata,
   output logic                       pready
);

   // Configuration registers.
   logic [CFG_W-1:0] time_step_ff, angle_noise_ff, bias_noise_ff, meas_noise_ff;
   logic             csr_wr;

   assign pready = 1'b1;
   assign csr_wr = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         time_step_ff <= TIME_STEP_RESET;
         angle_noise_ff <= ANGLE_NOISE_RESET;
         bias_noise_ff <= BIAS_NOISE_RESET;
         meas_noise_ff <= MEAS_NOISE_RESET;
      end else if (csr_wr) begin
         unique case (csr_idx_type'(paddr[3:2]))
            CSR_TIME_STEP:   time_step_ff <= pwdata[CFG_W-1:0];
            CSR_ANGLE_NOISE: angle_noise_ff <= pwdata[CFG_W-1:0];
            CSR_BIAS_NOISE:  bias_noise_ff <= pwdata[CFG_W-1:0];
            CSR_MEAS_NOISE:  meas_noise_ff <= pwdata[CFG_W-1:0];
         endcase
      end
   end

   always_comb begin
      unique case (csr_idx_type'(paddr[3:2]))
         CSR_TIME_STEP:   prdata = {1'b0, time_step_ff};
         CSR_ANGLE_NOISE: prdata = {1'b0, angle_noise_ff};
         CSR_BIAS_NOISE:  prdata = {1'b0, bias_noise_ff};
         CSR_MEAS_NOISE:  prdata = {1'b0, meas_noise_ff};
      endcase
   end

   // Per-axis filter state.
   logic signed [31:0] angle_store_ff [NUM_AXES];
   logic signed [31:0] bias_store_ff [NUM_AXES];
   logic signed [31:0] p00_store_ff [NUM_AXES];
   logic signed [31:0] p01_store_ff [NUM_AXES];
   logic signed [31:0] p10_store_ff [NUM_AXES];
   logic signed [31:0] p11_store_ff [NUM_AXES];

   // Sequencer and working registers.
   state_type          state_ff, state_in;
   logic signed [31:0] ang_ff, ang_in, bias_ff, bias_in;
   logic signed [31:0] p00_ff, p00_in, p01_ff, p01_in, p10_ff, p10_in, p11_ff, p11_in;
   logic signed [31:0] rate_ff, rate_in, tmp_ff, tmp_in, d11_ff, d11_in;
   logic signed [31:0] err_ff, err_in, k0_ff, k0_in, k1_ff, k1_in;
   logic signed [31:0] gyro_ff, gyro_in, meas_ff, meas_in;
   logic [31:0]        e_ff, e_in;
   logic [1:0]         axis_ff, axis_in;
   logic [AXIS_IDX_W-1:0] idx_ff, idx_in;
   logic               bad_ff, bad_in;
   logic signed [63:0] prod_ff, prod_in;
   logic signed [31:0] mq_ff, mq_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_data_ff, rsp_data_in;

   // Shared unit operands.
   logic signed [31:0] mul_a, mul_b;
   logic signed [33:0] alu_x, alu_y, alu_z, alu_sum;
   logic signed [31:0] alu_res;
   logic [63:0]        rnd_sum;
   dst_type            dst;
   logic               div_start, div_done;
   logic signed [31:0] div_numer, div_quot;
   logic               store_we, out_go, req_take, axis_ok;
   logic [AXIS_IDX_W-1:0] req_idx;
   logic signed [31:0] dt_s, qa_s, qb_s;

   assign dt_s = $signed({1'b0, time_step_ff});
   assign qa_s = $signed({1'b0, angle_noise_ff});
   assign qb_s = $signed({1'b0, bias_noise_ff});

   assign req_stall = (state_ff != ST_IDLE);
   assign req_take = req_valid && !req_stall;
   assign axis_ok = ({30'd0, req_data.axis} < NUM_AXES);
   assign req_idx = AXIS_IDX_W'(req_data.axis);
   assign out_go = !rsp_valid_ff || !rsp_stall;

   // Shared multiplier, then rounding to nearest (halves up) and saturation.
   assign prod_in = mul_a * mul_b;
   assign rnd_sum = prod_ff + 64'sd32768;
   assign mq_in = sat48(rnd_sum[63:16]);

   gak_divider u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .numer (div_numer),
      .denom (e_ff),
      .done  (div_done),
      .quot  (div_quot)
   );

   // Next state, shared unit operands and register updates.
   always_comb begin
      state_in = state_ff;
      ang_in = ang_ff;   bias_in = bias_ff;
      p00_in = p00_ff;   p01_in = p01_ff;   p10_in = p10_ff;   p11_in = p11_ff;
      rate_in = rate_ff; tmp_in = tmp_ff;   d11_in = d11_ff;
      err_in = err_ff;   k0_in = k0_ff;     k1_in = k1_ff;
      gyro_in = gyro_ff; meas_in = meas_ff; e_in = e_ff;
      axis_in = axis_ff; idx_in = idx_ff;   bad_in = bad_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in = rsp_data_ff;
      mul_a = '0;
      mul_b = '0;
      alu_x = '0;
      alu_y = '0;
      alu_z = '0;
      dst = D_NONE;
      div_start = 1'b0;
      div_numer = p00_ff;
      store_we = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               axis_in = req_data.axis;
               idx_in = req_idx;
               bad_in = !axis_ok;
               gyro_in = req_data.gyro_rate;
               meas_in = req_data.measured_angle;
               if (axis_ok) begin
                  ang_in = angle_store_ff[req_idx];
                  bias_in = bias_store_ff[req_idx];
                  p00_in = p00_store_ff[req_idx];
                  p01_in = p01_store_ff[req_idx];
                  p10_in = p10_store_ff[req_idx];
                  p11_in = p11_store_ff[req_idx];
                  state_in = ST_P0;
               end else begin
                  state_in = ST_WB;
               end
            end
         end
         // Predict.
         ST_P0: begin
            alu_x = 34'(gyro_ff); alu_y = -34'(bias_ff); dst = D_RATE;
            mul_a = p11_ff; mul_b = dt_s;
            state_in = ST_P1;
         end
         ST_P1: begin
            alu_x = 34'(qa_s); alu_y = -34'(p01_ff); alu_z = -34'(p10_ff); dst = D_TMP;
            mul_a = qb_s; mul_b = dt_s;
            state_in = ST_P2;
         end
         ST_P2: begin
            alu_x = 34'(p01_ff); alu_y = -34'(mq_ff); dst = D_P01;
            d11_in = mq_ff;
            mul_a = rate_ff; mul_b = dt_s;
            state_in = ST_P3;
         end
         ST_P3: begin
            alu_x = 34'(p11_ff); alu_y = 34'(mq_ff); dst = D_P11;
            mul_a = tmp_ff; mul_b = dt_s;
            state_in = ST_P4;
         end
         ST_P4: begin
            alu_x = 34'(ang_ff); alu_y = 34'(mq_ff); dst = D_ANG;
            state_in = ST_P5;
         end
         ST_P5: begin
            alu_x = 34'(p00_ff); alu_y = 34'(mq_ff); dst = D_P00;
            state_in = ST_P6;
         end
         ST_P6: begin
            alu_x = 34'(p10_ff); alu_y = -34'(d11_ff); dst = D_P10;
            state_in = ST_P7;
         end
         ST_P7: begin
            alu_x = 34'(meas_ff); alu_y = -34'(ang_ff); dst = D_ERR;
            state_in = ST_P8;
         end
         ST_P8: begin
            alu_x = 34'($signed({1'b0, meas_noise_ff})); alu_y = 34'(p00_ff); dst = D_E;
            state_in = ST_K0_GO;
         end
         // Gains.
         ST_K0_GO: begin
            div_start = 1'b1;
            div_numer = p00_ff;
            state_in = ST_K0_WAIT;
         end
         ST_K0_WAIT: begin
            if (div_done) begin
               k0_in = div_quot;
               state_in = ST_K1_GO;
            end
         end
         ST_K1_GO: begin
            div_start = 1'b1;
            div_numer = p10_ff;
            state_in = ST_K1_WAIT;
         end
         ST_K1_WAIT: begin
            if (div_done) begin
               k1_in = div_quot;
               state_in = ST_C0;
            end
         end
         // Correct; each product passes the product and rounded-product registers before use.
         ST_C0: begin
            mul_a = k0_ff; mul_b = p00_ff;
            state_in = ST_C1;
         end
         ST_C1: begin
            mul_a = k0_ff; mul_b = p01_ff;
            state_in = ST_C2;
         end
         ST_C2: begin
            mul_a = k1_ff; mul_b = p00_ff;
            alu_x = 34'(p00_ff); alu_y = -34'(mq_ff); dst = D_P00;
            state_in = ST_C3;
         end
         ST_C3: begin
            mul_a = k1_ff; mul_b = p01_ff;
            alu_x = 34'(p01_ff); alu_y = -34'(mq_ff); dst = D_P01;
            state_in = ST_C4;
         end
         ST_C4: begin
            mul_a = k0_ff; mul_b = err_ff;
            alu_x = 34'(p10_ff); alu_y = -34'(mq_ff); dst = D_P10;
            state_in = ST_C5;
         end
         ST_C5: begin
            mul_a = k1_ff; mul_b = err_ff;
            alu_x = 34'(p11_ff); alu_y = -34'(mq_ff); dst = D_P11;
            state_in = ST_C6;
         end
         ST_C6: begin
            alu_x = 34'(ang_ff); alu_y = 34'(mq_ff); dst = D_ANG;
            state_in = ST_C7;
         end
         ST_C7: begin
            alu_x = 34'(bias_ff); alu_y = 34'(mq_ff); dst = D_BIAS;
            state_in = ST_C8;
         end
         ST_C8: begin
            alu_x = 34'(gyro_ff); alu_y = -34'(bias_ff); dst = D_RATE;
            state_in = ST_WB;
         end
         // Write back and hand the result to the output register.
         ST_WB: begin
            if (out_go) begin
               store_we = !bad_ff;
               rsp_valid_in = 1'b1;
               rsp_data_in.axis_out = axis_ff;
               rsp_data_in.angle_estimate = bad_ff ? 32'sd0 : ang_ff;
               rsp_data_in.corrected_rate = bad_ff ? 32'sd0 : rate_ff;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase

      // Shared adder with saturation.
      alu_sum = alu_x + alu_y + alu_z;
      alu_res = sat34(alu_sum);

      unique case (dst)
         D_NONE: ;
         D_RATE: rate_in = alu_res;
         D_TMP:  tmp_in = alu_res;
         D_P00:  p00_in = alu_res;
         D_P01:  p01_in = alu_res;
         D_P10:  p10_in = alu_res;
         D_P11:  p11_in = alu_res;
         D_ANG:  ang_in = alu_res;
         D_BIAS: bias_in = alu_res;
         D_ERR:  err_in = alu_res;
         D_E:    e_in = (alu_sum < 34'sd1) ? 32'd1 : alu_sum[31:0];
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      ang_ff <= ang_in;     bias_ff <= bias_in;
      p00_ff <= p00_in;     p01_ff <= p01_in;   p10_ff <= p10_in;   p11_ff <= p11_in;
      rate_ff <= rate_in;   tmp_ff <= tmp_in;   d11_ff <= d11_in;
      err_ff <= err_in;     k0_ff <= k0_in;     k1_ff <= k1_in;
      gyro_ff <= gyro_in;   meas_ff <= meas_in; e_ff <= e_in;
      axis_ff <= axis_in;   idx_ff <= idx_in;   bad_ff <= bad_in;
      prod_ff <= prod_in;   mq_ff <= mq_in;
      rsp_data_ff <= rsp_data_in;
   end

   // Per-axis state: identity covariance and zero angle and bias at reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_AXES; i++) begin
            angle_store_ff[i] <= '0;
            bias_store_ff[i] <= '0;
            p00_store_ff[i] <= Q_ONE;
            p01_store_ff[i] <= '0;
            p10_store_ff[i] <= '0;
            p11_store_ff[i] <= Q_ONE;
         end
      end else if (store_we) begin
         angle_store_ff[idx_ff] <= ang_ff;
         bias_store_ff[idx_ff] <= bias_ff;
         p00_store_ff[idx_ff] <= p00_ff;
         p01_store_ff[idx_ff] <= p01_ff;
         p10_store_ff[idx_ff] <= p10_ff;
         p11_store_ff[idx_ff] <= p11_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_data_ff;

   // The divider only finishes while the sequencer waits for it.
   a_div_done_in_wait: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == ST_K0_WAIT || state_ff == ST_K1_WAIT))
      else $error("divider finished outside a gain wait step");

   // An accepted word always starts the sequencer.
   a_take_starts: assert property (@(posedge clock) disable iff (reset)
      req_take |=> (state_ff != ST_IDLE))
      else $error("accepted word did not start the sequencer");

   // A new result appears only out of the write-back step.
   a_rsp_from_wb: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_WB))
      else $error("result raised outside write-back");

endmodule

`default_nettype wire

// ===== dv/gak_checker.sv =====
`timescale 1ns / 1ps

module gak_checker
   import gak_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_stall,
   input  req_type               req_data,
   input  logic                  rsp_valid,
   input  logic                  rsp_stall,
   input  rsp_type               rsp_data,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic                  pready,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output int                    fail_count,
   output int                    pending_count
);

   // Shadow copy of the filter configuration.
   logic [30:0] dt_q, qa_q, qb_q, r_q;

   // Shadow copy of the per-axis filter state.
   logic signed [31:0] ang_m [NUM_AXES];
   logic signed [31:0] bias_m [NUM_AXES];
   logic signed [31:0] pm [NUM_AXES][4];

   rsp_type estimate_q[$];

   assign pending_count = estimate_q.size();

   function automatic longint clamp32(input longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   // Q16.16 product, rounded half up, then clamped.
   function automatic longint qmul(input longint a, input longint b);
      longint p;
      longint q;
      p = a * b + 32768;
      q = p / 65536;
      if (p % 65536 < 0) q = q - 1;
      return clamp32(q);
   endfunction

   // Q16.16 quotient, rounded half away from zero, then clamped.
   function automatic longint qdiv(input longint p, input longint e);
      longint n;
      longint mag;
      longint q;
      n = p * 65536;
      mag = (n < 0) ? -n : n;
      q = (mag + e / 2) / e;
      return clamp32((n < 0) ? -q : q);
   endfunction

   // Run one filter update on the shadow state and return the result word.
   function automatic rsp_type filter_update(input req_type w);
      rsp_type o;
      longint meas, gyro, dt, ang, bias, p00, p01, p10, p11, d11, e, k0, k1;
      longint t0, t1, err, rate;
      int a;
      o.axis_out = w.axis;
      o.angle_estimate = '0;
      o.corrected_rate = '0;
      a = w.axis;
      if (a >= NUM_AXES) return o;
      meas = w.measured_angle;
      gyro = w.gyro_rate;
      dt = dt_q;
      ang = ang_m[a];
      bias = bias_m[a];
      p00 = pm[a][0]; p01 = pm[a][1]; p10 = pm[a][2]; p11 = pm[a][3];
      // Predict.
      rate = clamp32(gyro - bias);
      ang = clamp32(ang + qmul(rate, dt));
      p00 = clamp32(p00 + qmul(clamp32(longint'(qa_q) - p01 - p10), dt));
      d11 = qmul(p11, dt);
      p01 = clamp32(p01 - d11);
      p10 = clamp32(p10 - d11);
      p11 = clamp32(p11 + qmul(longint'(qb_q), dt));
      err = clamp32(meas - ang);
      // Gain, with the innovation variance kept positive.
      e = longint'(r_q) + p00;
      if (e < 1) e = 1;
      k0 = qdiv(p00, e);
      k1 = qdiv(p10, e);
      // Correct.
      t0 = p00;
      t1 = p01;
      p00 = clamp32(p00 - qmul(k0, t0));
      p01 = clamp32(p01 - qmul(k0, t1));
      p10 = clamp32(p10 - qmul(k1, t0));
      p11 = clamp32(p11 - qmul(k1, t1));
      ang = clamp32(ang + qmul(k0, err));
      bias = clamp32(bias + qmul(k1, err));
      rate = clamp32(gyro - bias);
      ang_m[a] = ang[31:0];
      bias_m[a] = bias[31:0];
      pm[a][0] = p00[31:0]; pm[a][1] = p01[31:0];
      pm[a][2] = p10[31:0]; pm[a][3] = p11[31:0];
      o.angle_estimate = ang[31:0];
      o.corrected_rate = rate[31:0];
      return o;
   endfunction

   // Track configuration writes, input words and result words.
   always @(posedge clock) begin
      rsp_type exp_w;
      if (reset) begin
         dt_q <= TIME_STEP_RESET;
         qa_q <= ANGLE_NOISE_RESET;
         qb_q <= BIAS_NOISE_RESET;
         r_q <= MEAS_NOISE_RESET;
         for (int i = 0; i < NUM_AXES; i++) begin
            ang_m[i] = '0;
            bias_m[i] = '0;
            pm[i][0] = Q_ONE; pm[i][1] = '0; pm[i][2] = '0; pm[i][3] = Q_ONE;
         end
         estimate_q.delete();
         fail_count <= 0;
      end else begin
         if (psel && penable && pwrite && pready) begin
            case (csr_idx_type'(paddr[3:2]))
               CSR_TIME_STEP: dt_q <= pwdata[30:0];
               CSR_ANGLE_NOISE: qa_q <= pwdata[30:0];
               CSR_BIAS_NOISE: qb_q <= pwdata[30:0];
               CSR_MEAS_NOISE: r_q <= pwdata[30:0];
               default: ;
            endcase
         end
         if (req_valid && !req_stall) estimate_q.push_back(filter_update(req_data));
         if (rsp_valid && !rsp_stall) begin
            if (estimate_q.size() == 0) begin
               $display("%0t: unexpected result word %h", $time, rsp_data);
               fail_count <= fail_count + 1;
            end else begin
               exp_w = estimate_q.pop_front();
               if (rsp_data.axis_out !== exp_w.axis_out ||
                   rsp_data.angle_estimate !== exp_w.angle_estimate ||
                   rsp_data.corrected_rate !== exp_w.corrected_rate) begin
                  $display("%0t: mismatch expected axis %0d angle %0d rate %0d",
                           $time, exp_w.axis_out, exp_w.angle_estimate,
                           exp_w.corrected_rate);
                  $display("%0t:          actual   axis %0d angle %0d rate %0d",
                           $time, rsp_data.axis_out, rsp_data.angle_estimate,
                           rsp_data.corrected_rate);
                  fail_count <= fail_count + 1;
               end
            end
         end
      end
   end

endmodule

// ===== dv/tb_gyro_accel_angle_kalman_unit.sv =====
`timescale 1ns / 1ps

module tb_gyro_accel_angle_kalman_unit;
   import gak_pkg::*;

   localparam int WATCHDOG_LIMIT = 20000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   req_type req_data = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   rsp_type rsp_data;
   logic psel = 1'b0;
   logic penable = 1'b0;
   logic pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr = '0;
   logic [CSR_DATA_W-1:0] pwdata = '0;
   logic [CSR_DATA_W-1:0] prdata;
   logic pready;
   int fail_count;
   int pending_count;
   int idle_cycles = 0;
   int stall_pct = 25;
   bit hold_off = 1'b0;

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   gyro_accel_angle_kalman_unit u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   gak_checker u_checker (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
      .paddr(paddr), .pwdata(pwdata),
      .fail_count(fail_count), .pending_count(pending_count)
   );

   // Result side stall: random, or held for a long stretch on request.
   always @(negedge clock) begin
      if (hold_off) rsp_stall <= 1'b1;
      else rsp_stall <= ($urandom_range(99) < stall_pct);
   end

   // Watchdog on cycles with no word moving on either channel.
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || reset)
         idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   // Setup cycle, access cycle, then an idle cycle on the port.
   task automatic write_csr(input csr_idx_type idx, input logic [31:0] val);
      psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
      paddr <= CSR_ADDR_W'(idx) << 2; pwdata <= val;
      @(negedge clock);
      penable <= 1'b1;
      @(negedge clock);
      psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
      @(negedge clock);
   endtask

   // Offer one word and hold it until taken; the next word or an idle
   // cycle replaces it at the following falling edge.
   task automatic send_word(input logic [1:0] ax, input logic [31:0] ma,
                            input logic [31:0] gr, input int gap_pct);
      while ($urandom_range(99) < gap_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data.axis <= ax;
      req_data.measured_angle <= ma;
      req_data.gyro_rate <= gr;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
   endtask

   // Stop offering words, wait until every result is in, then idle a while.
   task automatic drain();
      req_valid <= 1'b0;
      while (pending_count != 0) @(negedge clock);
      repeat (200) @(negedge clock);
   endtask

   function automatic logic [31:0] rand_angle();
      case ($urandom_range(3))
         0: return $urandom;
         1: return 32'($signed($urandom_range(180 * 65536)) - 90 * 65536);
         2: return 32'($signed($urandom_range(2000)) - 1000);
         default: return {$urandom_range(1) ? 32'h7FFFFFFF : 32'h80000000};
      endcase
   endfunction

   task automatic random_phase(input int n, input int gap_pct);
      for (int i = 0; i < n; i++)
         send_word(($urandom_range(19) == 0) ? 2'd3 : 2'($urandom_range(2)),
                   rand_angle(), rand_angle(), gap_pct);
   endtask

   initial begin
      repeat (7) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed: extremes, every axis, out-of-range axis, defaults.
      send_word(2'd0, 32'd0, 32'd0, 0);
      send_word(2'd1, 32'h7FFFFFFF, 32'h7FFFFFFF, 0);
      send_word(2'd2, 32'h80000000, 32'h80000000, 0);
      send_word(2'd3, 32'hFFFFFFFF, 32'h12345678, 0);
      send_word(2'd0, 32'h7FFFFFFF, 32'h80000000, 0);
      send_word(2'd1, 32'h80000000, 32'h7FFFFFFF, 0);
      send_word(2'd2, 32'h005A0000, 32'hFFF60000, 0);
      send_word(2'd0, 32'hFFFFFFFF, 32'h00000001, 0);
      drain();

      // Extreme settings, including a zero step and a saturating step.
      write_csr(CSR_TIME_STEP, 32'hFFFFFFFF);
      write_csr(CSR_ANGLE_NOISE, 32'h7FFFFFFF);
      write_csr(CSR_BIAS_NOISE, 32'h7FFFFFFF);
      write_csr(CSR_MEAS_NOISE, 32'd1);
      for (int i = 0; i < 8; i++)
         send_word(2'(i % 3), rand_angle(), rand_angle(), 0);
      drain();
      write_csr(CSR_TIME_STEP, 32'd0);
      write_csr(CSR_ANGLE_NOISE, 32'd0);
      write_csr(CSR_BIAS_NOISE, 32'd0);
      write_csr(CSR_MEAS_NOISE, 32'h7FFFFFFF);
      for (int i = 0; i < 6; i++)
         send_word(2'(i % 3), rand_angle(), rand_angle(), 0);
      drain();

      // Typical settings, random traffic with idling.
      write_csr(CSR_TIME_STEP, 32'd655);
      write_csr(CSR_ANGLE_NOISE, 32'd100);
      write_csr(CSR_BIAS_NOISE, 32'd300);
      write_csr(CSR_MEAS_NOISE, 32'd19661);
      random_phase(200, 25);

      // Receiver holds off while the sender keeps offering words.
      fork
         begin
            hold_off = 1'b1;
            repeat (600) @(negedge clock);
            hold_off = 1'b0;
         end
         random_phase(10, 0);
      join
      drain();

      // Random settings, then a stretch with no idling.
      write_csr(CSR_TIME_STEP, $urandom_range(4000));
      write_csr(CSR_ANGLE_NOISE, $urandom_range(2000));
      write_csr(CSR_BIAS_NOISE, $urandom_range(2000));
      write_csr(CSR_MEAS_NOISE, $urandom_range(1, 1 << 20));
      stall_pct = 0;
      random_phase(150, 0);
      stall_pct = 25;
      drain();

      // Fully random registers, including huge values.
      write_csr(CSR_TIME_STEP, $urandom);
      write_csr(CSR_ANGLE_NOISE, $urandom);
      write_csr(CSR_BIAS_NOISE, $urandom);
      write_csr(CSR_MEAS_NOISE, $urandom_range(1, 32'h7FFFFFFF));
      random_phase(250, 25);

      drain();
      if (fail_count == 0) $display("tb: success");
      else $display("tb: failure");
      $finish;
   end

endmodule

// ===== gyro_accel_angle_kalman_unit.f =====
rtl/gak_pkg.sv
rtl/gak_divider.sv
rtl/gyro_accel_angle_kalman_unit.sv
dv/gak_checker.sv
dv/tb_gyro_accel_angle_kalman_unit.sv
